// ===== rtl/core/lcdw_pkg.sv =====
// Shared types, codes and constants for the character LCD write sequencer.
package lcdw_pkg;

  // Request codes on the input channel
  typedef enum logic [2:0] {
    REQ_TICK = 3'd0,
    REQ_INIT = 3'd1,
    REQ_CMD  = 3'd2,
    REQ_DATA = 3'd3,
    REQ_POS  = 3'd4
  } req_code_t;

  // Classified item as seen by the back end
  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_INIT = 2'd1,
    KIND_SEND = 2'd2
  } item_kind_t;

  typedef struct packed {
    item_kind_t  kind;
    logic [7:0]  byte_val;
    logic        sel;
  } queue_entry_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_FUNCTION_SET = 3'd0,
    CFG_DISPLAY_ON   = 3'd1,
    CFG_CLEAR        = 3'd2,
    CFG_ROW2_OFFSET  = 3'd3,
    CFG_STARTUP_WAIT = 3'd4,
    CFG_PULSE_WAIT   = 3'd5,
    CFG_SHORT_WAIT   = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] function_set_word;
    logic [7:0] display_on_word;
    logic [7:0] clear_word;
    logic [6:0] second_row_offset;
    logic [5:0] startup_wait;
    logic [5:0] pulse_wait;
    logic [5:0] short_wait;
  } lcd_cfg_t;

  // Register reset values
  localparam logic [7:0] RST_FUNCTION_SET = 8'd44;
  localparam logic [7:0] RST_DISPLAY_ON   = 8'd12;
  localparam logic [7:0] RST_CLEAR        = 8'd1;
  localparam logic [6:0] RST_ROW2_OFFSET  = 7'd63;
  localparam logic [5:0] RST_STARTUP_WAIT = 6'd50;
  localparam logic [5:0] RST_PULSE_WAIT   = 6'd5;
  localparam logic [5:0] RST_SHORT_WAIT   = 6'd1;

  // Sequencer step numbers
  localparam logic [5:0] STEP_IDLE             = 6'd0;
  localparam logic [5:0] STEP_INIT_FIRST       = 6'd1;
  localparam logic [5:0] STEP_INIT_BYTES_FIRST = 6'd10;
  localparam logic [5:0] STEP_INIT_BYTES_LAST  = 6'd27;
  localparam logic [5:0] STEP_SEND_FIRST       = 6'd28;
  localparam logic [5:0] STEP_SEND_LAST        = 6'd33;
  localparam logic [5:0] BYTE_STEPS            = 6'd6;

  localparam logic [3:0] NIBBLE_WAKE  = 4'h3;
  localparam logic [3:0] NIBBLE_4BIT  = 4'h2;
  localparam logic [7:0] SET_ADDR_CMD = 8'h80;

endpackage

// ===== rtl/core/lcdw_front.sv =====
// Front end: accepts input items and classifies them into queue entries.
module lcdw_front (
  input  logic                  valid,
  output logic                  ready,
  input  logic [2:0]            req_type,
  input  logic [7:0]            byte_value,
  input  logic [1:0]            row,
  input  logic [6:0]            column,
  input  logic [6:0]            second_row_offset,
  output logic                  push_valid,
  input  logic                  push_ready,
  output lcdw_pkg::queue_entry_t push_entry
);
  import lcdw_pkg::*;

  logic [6:0] addr;

  // Pass the handshake straight to the queue
  assign push_valid = valid;
  assign ready      = push_ready;

  // Form the display address for a position request
  always_comb begin
    case (row)
      2'd1:    addr = column - 7'd1;
      2'd2:    addr = column + second_row_offset;
      default: addr = column;
    endcase
  end

  // Classify the request
  always_comb begin
    push_entry.kind     = KIND_TICK;
    push_entry.byte_val = byte_value;
    push_entry.sel      = 1'b0;
    unique case (req_type)
      REQ_INIT: push_entry.kind = KIND_INIT;
      REQ_CMD:  push_entry.kind = KIND_SEND;
      REQ_DATA: begin
        push_entry.kind = KIND_SEND;
        push_entry.sel  = 1'b1;
      end
      REQ_POS: begin
        push_entry.kind     = KIND_SEND;
        push_entry.byte_val = SET_ADDR_CMD | {1'b0, addr};
      end
      default: push_entry.kind = KIND_TICK;
    endcase
  end

endmodule

// ===== rtl/core/lcdw_queue.sv =====
// Two-entry queue between the front end and the back end.
module lcdw_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push_valid,
  output logic                   push_ready,
  input  lcdw_pkg::queue_entry_t push_entry,
  output logic                   pop_valid,
  input  logic                   pop_ready,
  output lcdw_pkg::queue_entry_t pop_entry
);
  import lcdw_pkg::*;

  queue_entry_t entries [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         push;
  logic         pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_entry  = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/lcdw_back.sv =====
// Back end: steps the timed pin sequence, one queue entry per unstalled cycle.
module lcdw_back (
  input  logic                   clk,
  input  logic                   rst,
  input  lcdw_pkg::lcd_cfg_t     cfg,
  input  logic                   pop_valid,
  output logic                   pop_ready,
  input  lcdw_pkg::queue_entry_t pop_entry,
  output logic                   valid,
  input  logic                   ready,
  output logic                   enable_pin,
  output logic                   select_pin,
  output logic [3:0]             data_nibble,
  output logic                   busy_res,
  output logic                   dropped
);
  import lcdw_pkg::*;

  logic [5:0] phase_step, phase_step_next;
  logic [5:0] wait_count, wait_count_next;
  logic [7:0] held_byte, held_byte_next;
  logic       held_select, held_select_next;
  logic       enable_level, enable_level_next;
  logic       select_level, select_level_next;
  logic [3:0] data_level, data_level_next;
  logic       drop_flag, drop_flag_next;
  logic       out_valid, out_valid_next;
  logic       pop;

  // Take an entry only when the result slot is free or being emptied
  assign pop_ready   = !out_valid || ready;
  assign pop         = pop_valid && pop_ready;
  assign valid       = out_valid;
  assign enable_pin  = enable_level;
  assign select_pin  = select_level;
  assign data_nibble = data_level;
  assign busy_res    = (phase_step != STEP_IDLE);
  assign dropped     = drop_flag;

  // Sequencer next state
  always_comb begin
    logic       adv;
    logic       apply_en;
    logic [5:0] apply_p;
    logic [5:0] np;
    logic [5:0] off;
    logic [2:0] b;
    logic [1:0] k;
    logic       byte_mode;
    logic [5:0] hold;

    phase_step_next   = phase_step;
    wait_count_next   = wait_count;
    held_byte_next    = held_byte;
    held_select_next  = held_select;
    enable_level_next = enable_level;
    select_level_next = select_level;
    data_level_next   = data_level;
    drop_flag_next    = drop_flag;
    adv       = 1'b0;
    apply_en  = 1'b0;
    apply_p   = phase_step;
    np        = STEP_IDLE;
    off       = 6'd0;
    b         = 3'd0;
    k         = 2'd0;
    byte_mode = 1'b0;
    hold      = 6'd0;

    if (pop) begin
      drop_flag_next = 1'b0;
      // Drop a request while busy; it still advances the sequence
      if (pop_entry.kind != KIND_TICK && phase_step != STEP_IDLE) begin
        drop_flag_next = 1'b1;
        adv            = 1'b1;
      end else if (pop_entry.kind == KIND_INIT) begin
        apply_en = 1'b1;
        apply_p  = STEP_INIT_FIRST;
      end else if (pop_entry.kind == KIND_SEND) begin
        held_byte_next   = pop_entry.byte_val;
        held_select_next = pop_entry.sel;
        apply_en         = 1'b1;
        apply_p          = STEP_SEND_FIRST;
      end else begin
        adv = 1'b1;
      end

      // Count down the hold, then move to the next step
      if (adv && phase_step != STEP_IDLE) begin
        if (wait_count != 6'd0) begin
          wait_count_next = wait_count - 6'd1;
        end else begin
          if (phase_step == STEP_INIT_BYTES_LAST || phase_step >= STEP_SEND_LAST) begin
            np = STEP_IDLE;
          end else begin
            np = phase_step + 6'd1;
          end
          phase_step_next = np;
          if (np != STEP_IDLE) begin
            apply_en = 1'b1;
            apply_p  = np;
          end
        end
      end
    end

    // Apply the pin levels of the new step
    if (apply_en) begin
      phase_step_next = apply_p;
      if (apply_p >= STEP_INIT_BYTES_FIRST && apply_p <= STEP_INIT_BYTES_LAST) begin
        byte_mode = 1'b1;
        off       = apply_p - STEP_INIT_BYTES_FIRST;
        if (off < BYTE_STEPS) begin
          k = 2'd0;
          b = off[2:0];
        end else if (off < (BYTE_STEPS + BYTE_STEPS)) begin
          k = 2'd1;
          b = 3'(off - BYTE_STEPS);
        end else begin
          k = 2'd2;
          b = 3'(off - BYTE_STEPS - BYTE_STEPS);
        end
        // Load the init byte at the start of its transfer
        if (b == 3'd0) begin
          case (k)
            2'd0:    held_byte_next = cfg.function_set_word;
            2'd1:    held_byte_next = cfg.display_on_word;
            default: held_byte_next = cfg.clear_word;
          endcase
          held_select_next = 1'b0;
        end
      end else if (apply_p >= STEP_SEND_FIRST && apply_p <= STEP_SEND_LAST) begin
        byte_mode = 1'b1;
        b         = 3'(apply_p - STEP_SEND_FIRST);
      end

      if (byte_mode) begin
        case (b)
          3'd0: begin
            enable_level_next = 1'b0;
            select_level_next = held_select_next;
            data_level_next   = held_byte_next[7:4];
            hold              = 6'd0;
          end
          3'd1: begin
            enable_level_next = 1'b1;
            hold              = cfg.pulse_wait;
          end
          3'd2: begin
            enable_level_next = 1'b0;
            hold              = cfg.pulse_wait;
          end
          3'd3: begin
            data_level_next = held_byte_next[3:0];
            hold            = cfg.short_wait;
          end
          3'd4: begin
            enable_level_next = 1'b1;
            hold              = cfg.pulse_wait;
          end
          default: begin
            enable_level_next = 1'b0;
            hold              = 6'd0;
          end
        endcase
      end else begin
        case (apply_p)
          6'd1: begin
            enable_level_next = 1'b0;
            select_level_next = 1'b0;
            hold              = cfg.startup_wait;
          end
          6'd2: begin
            data_level_next = NIBBLE_WAKE;
            hold            = 6'd0;
          end
          6'd3, 6'd5, 6'd7: begin
            enable_level_next = 1'b1;
            hold              = (apply_p == 6'd3) ? cfg.pulse_wait : cfg.short_wait;
          end
          6'd4, 6'd6: begin
            enable_level_next = 1'b0;
            data_level_next   = NIBBLE_WAKE;
            hold              = 6'd0;
          end
          6'd8: begin
            enable_level_next = 1'b0;
            data_level_next   = NIBBLE_4BIT;
            hold              = 6'd0;
          end
          default: begin
            enable_level_next = 1'b1;
            hold              = cfg.pulse_wait;
          end
        endcase
      end
      wait_count_next = hold;
    end
  end

  // Hold the result until it is taken
  always_comb begin
    if (pop) begin
      out_valid_next = 1'b1;
    end else if (ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step   <= STEP_IDLE;
      wait_count   <= 6'd0;
      held_byte    <= 8'd0;
      held_select  <= 1'b0;
      enable_level <= 1'b0;
      select_level <= 1'b0;
      data_level   <= 4'd0;
      drop_flag    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      phase_step   <= phase_step_next;
      wait_count   <= wait_count_next;
      held_byte    <= held_byte_next;
      held_select  <= held_select_next;
      enable_level <= enable_level_next;
      select_level <= select_level_next;
      data_level   <= data_level_next;
      drop_flag    <= drop_flag_next;
      out_valid    <= out_valid_next;
    end
  end

endmodule

// ===== rtl/core/char_lcd_4bit_write_sequencer.sv =====
// Top level of the 4-bit character LCD write sequencer.
// Each input item is a tick or a request (init, command byte, data byte, cursor
// position); every item yields exactly one result carrying the E, RS and D7..D4
// levels, the busy flag and a flag telling that a request came while busy and
// was dropped. The block takes one item per clock cycle while results are taken:
// the front end classifies an item and forms the position address, a two-entry
// queue holds it, and the back end applies one sequencer step or hold count per
// item into the result register, which is loaded as the item leaves the queue.
// The back end stalls only while a result waits to be taken; the input stalls
// only once both queue entries are full behind such a waiting result.
// Configuration writes are taken every cycle and should be issued while idle.
module char_lcd_4bit_write_sequencer (
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] req_type,
  input  logic [7:0] byte_value,
  input  logic [1:0] row,
  input  logic [6:0] column,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic       enable_pin,
  output logic       select_pin,
  output logic [3:0] data_nibble,
  output logic       busy_res,
  output logic       dropped,
  // configuration channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import lcdw_pkg::*;

  lcd_cfg_t     cfg;
  logic         push_valid;
  logic         push_ready;
  queue_entry_t push_entry;
  logic         pop_valid;
  logic         pop_ready;
  queue_entry_t pop_entry;

  assign cfg_ready = 1'b1;

  // Configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.function_set_word <= RST_FUNCTION_SET;
      cfg.display_on_word   <= RST_DISPLAY_ON;
      cfg.clear_word        <= RST_CLEAR;
      cfg.second_row_offset <= RST_ROW2_OFFSET;
      cfg.startup_wait      <= RST_STARTUP_WAIT;
      cfg.pulse_wait        <= RST_PULSE_WAIT;
      cfg.short_wait        <= RST_SHORT_WAIT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FUNCTION_SET: cfg.function_set_word <= cfg_data;
        CFG_DISPLAY_ON:   cfg.display_on_word   <= cfg_data;
        CFG_CLEAR:        cfg.clear_word        <= cfg_data;
        CFG_ROW2_OFFSET:  cfg.second_row_offset <= cfg_data[6:0];
        CFG_STARTUP_WAIT: cfg.startup_wait      <= cfg_data[5:0];
        CFG_PULSE_WAIT:   cfg.pulse_wait        <= cfg_data[5:0];
        CFG_SHORT_WAIT:   cfg.short_wait        <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  lcdw_front u_front (
    .valid             (in_valid),
    .ready             (in_ready),
    .req_type          (req_type),
    .byte_value        (byte_value),
    .row               (row),
    .column            (column),
    .second_row_offset (cfg.second_row_offset),
    .push_valid        (push_valid),
    .push_ready        (push_ready),
    .push_entry        (push_entry)
  );

  lcdw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  lcdw_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_entry   (pop_entry),
    .valid       (out_valid),
    .ready       (out_ready),
    .enable_pin  (enable_pin),
    .select_pin  (select_pin),
    .data_nibble (data_nibble),
    .busy_res    (busy_res),
    .dropped     (dropped)
  );

endmodule
